[hw/rtl/nfca_card_subcarrier_encoder_assert.svh]
// Assertion macros for the port-level checker of the subcarrier encoder.
// Each macro samples on aclk and stays quiet while aresetn is low.
`ifndef NFCA_CARD_SUBCARRIER_ENCODER_ASSERT_SVH
`define NFCA_CARD_SUBCARRIER_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ncse_pkg.sv]
// Shared types and constants of the card-side subcarrier bit encoder.
// No dependencies; used by every module of the block.
package ncse_pkg;

    localparam int SLOT_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int SHIFT_W   = BYTE_W + 1;   // data byte plus parity
    localparam int SHORT_W   = 3;
    localparam int CNT_W     = 4;

    localparam logic [SLOT_W-1:0] SLOTS_ONE  = 16'h0055;
    localparam logic [SLOT_W-1:0] SLOTS_ZERO = 16'h5500;

    // Results of a full byte: eight data bits and the parity bit.
    localparam logic [CNT_W-1:0] FULL_COUNT = 4'd9;

    // Sequencer commands to the bit shifter.
    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctl_t;

    // What the sequencer emits toward the output register this cycle.
    typedef struct packed {
        logic emit;
        logic sof;
        logic last;
    } emit_info_t;

endpackage

[hw/rtl/ncse_shifter.sv]
// Bit shifter of the subcarrier encoder: holds data byte and parity, LSB first.
// Depends on ncse_pkg.
module ncse_shifter (
    input  logic                  aclk,
    input  ncse_pkg::shift_ctl_t  ctl,
    input  logic [7:0]            data_byte,
    input  logic                  parity_bit,
    output logic                  cur_bit
);
    import ncse_pkg::*;

    logic [SHIFT_W-1:0] sh_reg;
    logic [SHIFT_W-1:0] sh_next;

    always_comb begin
        sh_next = sh_reg;
        if (ctl.load) begin
            sh_next = {parity_bit, data_byte};
        end else if (ctl.shift) begin
            sh_next = {1'b0, sh_reg[SHIFT_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    assign cur_bit = sh_reg[0];

endmodule

[hw/rtl/ncse_seq.sv]
// Sequencer of the subcarrier encoder: counts bit times and steps the shifter.
// Depends on ncse_pkg.
module ncse_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  frame_start,
    input  logic [2:0]            short_bits,
    input  logic                  out_free,
    output ncse_pkg::shift_ctl_t  ctl,
    output ncse_pkg::emit_info_t  info
);
    import ncse_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sof_reg, sof_next;
    logic             accept;
    logic             emit;
    logic             last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (state_reg == ST_RUN) && out_free;
    // The start-of-frame bit is never last: at least one data bit follows.
    assign last     = !sof_reg && (cnt_reg == CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sof_next   = sof_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                    sof_next   = frame_start;
                    cnt_next   = (short_bits == '0) ? FULL_COUNT : CNT_W'(short_bits);
                end
            end
            ST_RUN: begin
                if (emit) begin
                    if (sof_reg) begin
                        sof_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sof_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sof_reg   <= sof_next;
        end
    end

    assign ctl.load  = accept;
    assign ctl.shift = emit && !sof_reg;
    assign info.emit = emit;
    assign info.sof  = sof_reg;
    assign info.last = last;

endmodule

[hw/rtl/nfca_card_subcarrier_encoder.sv]
// Card-side ISO 14443-A subcarrier bit encoder, one bit time per result.
// An input transfer loads the shift register; results leave from an output register.
// Throughput: one result per cycle while the sink is ready; an item takes N results
// (short_bits, or 9 for a full byte, plus 1 with frame start), and a new input is
// taken only once the sequencer has stepped the shift register through the last one.
// Reset (aresetn low, synchronous) empties the output and returns to idle.
module nfca_card_subcarrier_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] parity_bit, [11:9] short_bits
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] slot_levels
    output logic        m_tuser,   // [0] is_frame_start
    output logic        m_tlast
);
    import ncse_pkg::*;

    shift_ctl_t      ctl;
    emit_info_t      info;
    logic            cur_bit;
    logic            out_free;
    logic            m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_data_reg, m_data_next;
    logic            m_user_reg, m_user_next;
    logic            m_last_reg, m_last_next;

    assign out_free = !m_valid_reg || m_tready;

    ncse_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .frame_start (s_tuser),
        .short_bits  (s_tdata[11:9]),
        .out_free    (out_free),
        .ctl         (ctl),
        .info        (info)
    );

    ncse_shifter u_shifter (
        .aclk       (aclk),
        .ctl        (ctl),
        .data_byte  (s_tdata[7:0]),
        .parity_bit (s_tdata[8]),
        .cur_bit    (cur_bit)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (info.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = (info.sof || cur_bit) ? SLOTS_ONE : SLOTS_ZERO;
            m_user_next  = info.sof;
            m_last_next  = info.last;
        end else if (m_tready) begin
            // drop the transfer just taken
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hw/rtl/ncse_checker.sv]
// Port-level checker of the subcarrier encoder, bound to the top level.
// Depends on ncse_pkg and nfca_card_subcarrier_encoder_assert.svh.
`include "nfca_card_subcarrier_encoder_assert.svh"

module ncse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import ncse_pkg::*;

    logic stalled;
    logic in_xfer;
    logic slot_ok;
    logic sof_ok;

    assign stalled = m_tvalid && !m_tready;
    assign in_xfer = s_tvalid && s_tready;
    assign slot_ok = (m_tdata == SLOTS_ONE) || (m_tdata == SLOTS_ZERO);
    // The start-of-frame bit is a one and never closes an item.
    assign sof_ok  = (m_tdata == SLOTS_ONE) && !m_tlast;

    `NCSE_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "stalled result changed")
    `NCSE_ASSERT_SAME(a_slot_code, m_tvalid, slot_ok, "slot pattern is neither one nor zero")
    `NCSE_ASSERT_SAME(a_sof_one, m_tvalid && m_tuser, sof_ok, "bad start-of-frame result")
    `NCSE_ASSERT_NEXT(a_busy_after_in, in_xfer, !s_tready, "input taken while busy")

endmodule

bind nfca_card_subcarrier_encoder ncse_checker u_ncse_checker (.*);

[tb/nfca_card_subcarrier_encoder_tb.sv]
// Self-checking testbench for the card-side subcarrier bit encoder.
// Depends on ncse_pkg and nfca_card_subcarrier_encoder; predicts every bit time
// in a small scoreboard class and compares each result transfer field by field.
`timescale 1ns / 1ps

module nfca_card_subcarrier_encoder_tb;
    import ncse_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] levels;
        logic              sof;
        logic              last;
    } bit_time_t;

    class bit_time_scoreboard;
        bit_time_t pending_bit_times[$];
        int        mismatches;
        int        checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        function void push_bit(logic value, logic sof);
            bit_time_t bt;
            bt.levels = value ? SLOTS_ONE : SLOTS_ZERO;
            bt.sof    = sof;
            bt.last   = 1'b0;
            pending_bit_times.push_back(bt);
        endfunction

        // Expand one accepted byte into its bit times: frame start if set, data bits, parity for a full byte.
        function void note_transfer(logic [BYTE_W-1:0] data, logic parity, logic sof,
                                    logic [SHORT_W-1:0] short_bits);
            int nbits;
            bit_time_t tail;
            nbits = (short_bits == '0) ? BYTE_W : int'(short_bits);
            if (sof)
                push_bit(1'b1, 1'b1);
            for (int i = 0; i < nbits; i++)
                push_bit(data[i], 1'b0);
            if (short_bits == '0)
                push_bit(parity, 1'b0);
            tail = pending_bit_times.pop_back();
            tail.last = 1'b1;
            pending_bit_times.push_back(tail);
        endfunction

        task report_mismatch(string what, logic [SLOT_W-1:0] got, logic [SLOT_W-1:0] want);
            $display("%0t ns: bit time %0d %s mismatch: got %h, want %h",
                     $realtime, checked, what, got, want);
            mismatches++;
        endtask

        task check_bit_time(logic [SLOT_W-1:0] levels, logic sof, logic last);
            bit_time_t want;
            if (pending_bit_times.size() == 0) begin
                report_mismatch("unexpected result", levels, '0);
            end else begin
                want = pending_bit_times.pop_front();
                if (levels !== want.levels)
                    report_mismatch("slot_levels", levels, want.levels);
                if (sof !== want.sof)
                    report_mismatch("is_frame_start", SLOT_W'(sof), SLOT_W'(want.sof));
                if (last !== want.last)
                    report_mismatch("last_of_item", SLOT_W'(last), SLOT_W'(want.last));
            end
            checked++;
        endtask

        function int pending();
            return pending_bit_times.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] data_byte, [8] parity_bit, [11:9] short_bits
    logic        s_tuser  = 1'b0; // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] slot_levels
    logic        m_tuser;         // [0] is_frame_start
    logic        m_tlast;

    bit_time_scoreboard board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int shorts_sent   = 0;

    nfca_card_subcarrier_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Result side: random stalls, check every transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_bit_time(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one byte, hold until the transfer, then note it.
    task send_item(logic [BYTE_W-1:0] data, logic parity, logic sof,
                   logic [SHORT_W-1:0] short_bits);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, short_bits, parity, data};
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        board.note_transfer(data, parity, sof, short_bits);
        bytes_sent++;
        if (sof)
            frames_sent++;
        if (short_bits != '0)
            shorts_sent++;
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    // Mostly well-formed frames: frame start on the first byte, an optional short tail.
    task send_frames(int n_items);
        int sent;
        int len;
        logic [SHORT_W-1:0] tail_bits;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), SHORT_W'($urandom_range(7)));
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    tail_bits = (i == len - 1 && $urandom_range(2) == 0) ?
                                SHORT_W'($urandom_range(1, 7)) : '0;
                    send_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                              i == 0, tail_bits);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: byte extremes, parity both ways, every short length.
        send_item(8'h00, 1'b0, 1'b0, 3'd0);
        send_item(8'hFF, 1'b1, 1'b0, 3'd0);
        send_item(8'h01, 1'b1, 1'b1, 3'd0);
        send_item(8'h80, 1'b0, 1'b1, 3'd0);
        send_item(8'hA5, 1'b0, 1'b0, 3'd0);
        send_item(8'h5A, 1'b1, 1'b1, 3'd0);
        for (int n = 1; n <= 7; n++)
            send_item(8'h5A ^ n[7:0], n[0], n[1], n[SHORT_W-1:0]);
        send_item(8'hFF, 1'b1, 1'b0, 3'd7);
        send_item(8'h80, 1'b1, 1'b1, 3'd7);
        send_item(8'hFE, 1'b1, 1'b1, 3'd1);
        send_item(8'h01, 1'b0, 1'b0, 3'd1);
        send_item(8'h7F, 1'b1, 1'b0, 3'd0);
        drain();

        send_idle_pct = 8;
        recv_idle_pct = 61;
        send_frames(70);
        drain();

        send_idle_pct = 61;
        recv_idle_pct = 8;
        send_frames(70);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_frames(70);
        drain();

        repeat (20) @(posedge aclk);
        $display("Covered %0d bytes in %0d frames (%0d short), %0d bit times checked.",
                 bytes_sent, frames_sent, shorts_sent, board.checked);
        $display("Idle mixes: sender-light/receiver-heavy, reversed, and back-to-back.");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[nfca_card_subcarrier_encoder] OK");
        end else begin
            $display("[nfca_card_subcarrier_encoder] ERROR");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("Timed out with %0d bit times outstanding.", board.pending());
        $display("[nfca_card_subcarrier_encoder] ERROR");
        $finish;
    end

endmodule
